[hw/rtl/pal_pkg.sv]
// Shared types and constants of the positional array list.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package pal_pkg;

   // Fixed field widths of the request and response channels.
   localparam int OPCODE_WIDTH = 3;
   localparam int POS_WIDTH    = 7;
   localparam int VALUE_WIDTH  = 32;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_GET    = 3'd2,
      OP_FIND   = 3'd3,
      OP_CLEAR  = 3'd4
   } opcode_type;

   // Broadcast controls from the sequencer to every cell.
   typedef struct packed {
      logic shift_ins;   // commit an insert this cycle
      logic shift_del;   // commit a delete this cycle
      logic scan_get;    // probe captures the entry at the position
      logic scan_find;   // probe looks for the first matching entry
   } cell_ctrl_type;

   // Status bits of the probe that walks the chain.
   typedef struct packed {
      logic valid;
      logic hit;
   } probe_flags_type;

endpackage

`default_nettype wire

[hw/rtl/pal_req_if.sv]
// Request channel of the positional array list: valid/ready plus payload.
// Depends on pal_pkg for field widths.
`default_nettype none

interface pal_req_if;
   logic                              valid;
   logic                              ready;
   logic [pal_pkg::OPCODE_WIDTH-1:0]  opcode;
   logic [pal_pkg::POS_WIDTH-1:0]     position;
   logic [pal_pkg::VALUE_WIDTH-1:0]   value;

   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

`default_nettype wire

[hw/rtl/pal_rsp_if.sv]
// Response channel of the positional array list: valid/ready plus payload.
// Depends on pal_pkg for field widths.
`default_nettype none

interface pal_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             ok;
   logic [pal_pkg::VALUE_WIDTH-1:0]  read_value;
   logic [pal_pkg::POS_WIDTH-1:0]    found_position;
   logic [pal_pkg::POS_WIDTH-1:0]    list_length;
   logic                             is_empty;

   modport source (output valid, output ok, output read_value, output found_position,
                   output list_length, output is_empty, input ready);
   modport sink   (input valid, input ok, input read_value, input found_position,
                   input list_length, input is_empty, output ready);
endinterface

`default_nettype wire

[hw/rtl/pal_cell.sv]
// One cell of the list chain: holds one entry and one stage of the probe.
// Depends on pal_pkg for the control and probe structs.
`default_nettype none

module pal_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int IDX_WIDTH  = 7,
   parameter int INDEX      = 0
) (
   input  wire                            clock,
   input  wire                            reset,
   input  pal_pkg::cell_ctrl_type         ctrl,
   input  wire  [IDX_WIDTH-1:0]           pos_idx,
   input  wire  [IDX_WIDTH-1:0]           list_count,
   input  wire  [DATA_WIDTH-1:0]          key,
   input  wire  [DATA_WIDTH-1:0]          left_entry,
   input  wire  [DATA_WIDTH-1:0]          right_entry,
   output logic [DATA_WIDTH-1:0]          entry,
   input  pal_pkg::probe_flags_type       probe_in,
   input  wire  [IDX_WIDTH-1:0]           probe_idx_in,
   input  wire  [DATA_WIDTH-1:0]          probe_data_in,
   output pal_pkg::probe_flags_type       probe_out,
   output logic [IDX_WIDTH-1:0]           probe_idx_out,
   output logic [DATA_WIDTH-1:0]          probe_data_out
);

   localparam logic [IDX_WIDTH-1:0] MY_INDEX = IDX_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0]    entry_ff, entry_in;
   pal_pkg::probe_flags_type probe_ff, probe_in_nx;
   logic [IDX_WIDTH-1:0]     pidx_ff, pidx_in;
   logic [DATA_WIDTH-1:0]    pdata_ff, pdata_in;

   logic at_pos, after_pos, in_list, get_hit, find_hit;

   assign at_pos    = (MY_INDEX == pos_idx);
   assign after_pos = (MY_INDEX > pos_idx);
   assign in_list   = (MY_INDEX < list_count);
   assign get_hit   = ctrl.scan_get && at_pos;
   assign find_hit  = ctrl.scan_find && in_list && (entry_ff == key);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_ins) begin
         if (at_pos) begin
            entry_in = key;
         end else if (after_pos) begin
            entry_in = left_entry;
         end
      end else if (ctrl.shift_del) begin
         if (at_pos || after_pos) begin
            entry_in = right_entry;
         end
      end
   end

   // Earlier hits win: the probe visits cells in list order.
   always_comb begin
      probe_in_nx = probe_in;
      pidx_in     = probe_idx_in;
      pdata_in    = probe_data_in;
      if (probe_in.valid && !probe_in.hit && (get_hit || find_hit)) begin
         probe_in_nx.hit = 1'b1;
         pidx_in         = MY_INDEX;
         pdata_in        = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      pidx_ff  <= pidx_in;
      pdata_ff <= pdata_in;
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_nx;
      end
   end

   assign entry          = entry_ff;
   assign probe_out      = probe_ff;
   assign probe_idx_out  = pidx_ff;
   assign probe_data_out = pdata_ff;

endmodule

`default_nettype wire

[hw/rtl/positional_array_list.sv]
// Positional array list: a row of pal_cell entries driven by a small sequencer.
// Depends on pal_pkg, pal_req_if, pal_rsp_if and pal_cell.
//
// Usage
//  - req_chan carries opcode, 1-based position and value; rsp_chan returns ok,
//    read_value, found_position, list_length and is_empty, one response per
//    request, in order. A transfer happens when valid and ready are both high.
//  - Insert, clear and unused opcodes: the request goes from the idle state
//    to the commit state, which loads the response register once it is free.
//  - Get, delete and find send a probe down the cell chain, one cell per cycle,
//    then the scan state waits for it at the end of the chain and the commit
//    state loads the response register.
//  - One request is in flight at a time; req_chan.ready is high in the idle
//    state, which is entered again as soon as the result is loaded into the
//    response register, so a new request may transfer while a response waits.
//  - Insert/delete shift the cells from the position on in parallel at commit.
//  - Receiver stall: a finished request holds in the commit state until the
//    response register is free; the list does not change until then.
//  - Reset (synchronous, active high) empties the list and drops any request
//    and response in flight. Entry storage is not cleared; only entries below
//    the length are ever read.
`default_nettype none

module positional_array_list #(
   parameter int LIST_DEPTH = 64,
   parameter int DATA_WIDTH = 32
) (
   input wire          clock,
   input wire          reset,
   pal_req_if.sink     req_chan,
   pal_rsp_if.source   rsp_chan
);

   localparam int CNT_WIDTH = $clog2(LIST_DEPTH + 1);
   // Wide enough for any cell index and any request position.
   localparam int IDX_WIDTH = (CNT_WIDTH > pal_pkg::POS_WIDTH) ? CNT_WIDTH
                                                                : pal_pkg::POS_WIDTH;
   localparam int VW = pal_pkg::VALUE_WIDTH;
   localparam int PW = pal_pkg::POS_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   pal_pkg::opcode_type     op_ff, op_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]   key_ff, key_in;
   logic                    launch_ff, launch_in;
   logic                    res_hit_ff, res_hit_in;
   logic [IDX_WIDTH-1:0]    res_idx_ff, res_idx_in;
   logic [DATA_WIDTH-1:0]   res_data_ff, res_data_in;
   logic [CNT_WIDTH-1:0]    count_ff, count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [VW-1:0]           rsp_rd_ff, rsp_rd_in;
   logic [PW-1:0]           rsp_fpos_ff, rsp_fpos_in;
   logic [PW-1:0]           rsp_len_ff, rsp_len_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   // Request value trimmed or zero-extended to the entry width.
   logic [DATA_WIDTH+VW-1:0] key_wide;
   assign key_wide = {{DATA_WIDTH{1'b0}}, req_chan.value};

   logic accept, fire, scan_op;
   pal_pkg::opcode_type req_op;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_op         = pal_pkg::opcode_type'(req_chan.opcode);
   assign scan_op        = (req_op == pal_pkg::OP_GET) || (req_op == pal_pkg::OP_DELETE) ||
                           (req_op == pal_pkg::OP_FIND);
   assign fire           = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // Position checks against the current length
   logic [IDX_WIDTH-1:0] pos_ext, pos_idx, cnt_ext;
   logic                 pos_nz, ins_ok, rd_ok;
   assign pos_ext = IDX_WIDTH'(pos_ff);
   assign pos_idx = pos_ext - IDX_WIDTH'(1);
   assign cnt_ext = IDX_WIDTH'(count_ff);
   assign pos_nz  = (pos_ff != '0);
   // count + 1 cannot wrap here: the first term excludes a full list
   assign ins_ok  = (count_ff < CNT_WIDTH'(LIST_DEPTH)) && pos_nz &&
                    (pos_ext <= cnt_ext + IDX_WIDTH'(1));
   assign rd_ok   = pos_nz && (pos_ext <= cnt_ext);

   // ---------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------
   pal_pkg::cell_ctrl_type   ctrl;
   logic [DATA_WIDTH-1:0]    entry_w    [LIST_DEPTH];
   pal_pkg::probe_flags_type probe_f    [LIST_DEPTH+1];
   logic [IDX_WIDTH-1:0]     probe_idx  [LIST_DEPTH+1];
   logic [DATA_WIDTH-1:0]    probe_data [LIST_DEPTH+1];

   always_comb begin
      ctrl.shift_ins = fire && (op_ff == pal_pkg::OP_INSERT) && ins_ok;
      ctrl.shift_del = fire && (op_ff == pal_pkg::OP_DELETE) && rd_ok;
      ctrl.scan_get  = (op_ff == pal_pkg::OP_GET) || (op_ff == pal_pkg::OP_DELETE);
      ctrl.scan_find = (op_ff == pal_pkg::OP_FIND);
   end

   assign probe_f[0].valid = launch_ff;
   assign probe_f[0].hit   = 1'b0;
   assign probe_idx[0]     = '0;
   assign probe_data[0]    = '0;

   for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (k == 0) begin : g_head
         assign left_w = '0;
      end else begin : g_left
         assign left_w = entry_w[k-1];
      end
      if (k == LIST_DEPTH - 1) begin : g_tail
         assign right_w = '0;
      end else begin : g_right
         assign right_w = entry_w[k+1];
      end

      pal_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_WIDTH  (IDX_WIDTH),
         .INDEX      (k)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .pos_idx        (pos_idx),
         .list_count     (cnt_ext),
         .key            (key_ff),
         .left_entry     (left_w),
         .right_entry    (right_w),
         .entry          (entry_w[k]),
         .probe_in       (probe_f[k]),
         .probe_idx_in   (probe_idx[k]),
         .probe_data_in  (probe_data[k]),
         .probe_out      (probe_f[k+1]),
         .probe_idx_out  (probe_idx[k+1]),
         .probe_data_out (probe_data[k+1])
      );
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   logic [DATA_WIDTH+VW-1:0] rd_wide;
   logic [IDX_WIDTH-1:0]     fpos_ext;
   assign rd_wide      = {{VW{1'b0}}, res_data_ff};
   assign fpos_ext     = res_idx_ff + IDX_WIDTH'(1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      launch_in    = 1'b0;
      res_hit_in   = res_hit_ff;
      res_idx_in   = res_idx_ff;
      res_data_in  = res_data_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_fpos_in  = rsp_fpos_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_empty_in = rsp_empty_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               pos_in     = req_chan.position;
               key_in     = key_wide[DATA_WIDTH-1:0];
               res_hit_in = 1'b0;
               if (scan_op) begin
                  launch_in = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (probe_f[LIST_DEPTH].valid) begin
               res_hit_in  = probe_f[LIST_DEPTH].hit;
               res_idx_in  = probe_idx[LIST_DEPTH];
               res_data_in = probe_data[LIST_DEPTH];
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fire) begin
               rsp_ok_in   = 1'b0;
               rsp_rd_in   = '0;
               rsp_fpos_in = '0;
               case (op_ff)
                  pal_pkg::OP_INSERT: begin
                     if (ins_ok) begin
                        count_in  = count_ff + CNT_WIDTH'(1);
                        rsp_ok_in = 1'b1;
                     end
                  end
                  pal_pkg::OP_DELETE: begin
                     if (rd_ok) begin
                        count_in  = count_ff - CNT_WIDTH'(1);
                        rsp_ok_in = 1'b1;
                        rsp_rd_in = rd_wide[VW-1:0];
                     end
                  end
                  pal_pkg::OP_GET: begin
                     if (rd_ok) begin
                        rsp_ok_in = 1'b1;
                        rsp_rd_in = rd_wide[VW-1:0];
                     end
                  end
                  pal_pkg::OP_FIND: begin
                     if (res_hit_ff) begin
                        rsp_ok_in   = 1'b1;
                        rsp_fpos_in = fpos_ext[PW-1:0];
                     end
                  end
                  pal_pkg::OP_CLEAR: begin
                     count_in  = '0;
                     rsp_ok_in = 1'b1;
                  end
                  default: begin
                     // unused opcode: rejected, list unchanged
                  end
               endcase
               rsp_len_in   = PW'(count_in);
               rsp_empty_in = (count_in == '0);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      res_hit_ff   <= res_hit_in;
      res_idx_ff   <= res_idx_in;
      res_data_ff  <= res_data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_fpos_ff  <= rsp_fpos_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_empty_ff <= rsp_empty_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.ok             = rsp_ok_ff;
   assign rsp_chan.read_value     = rsp_rd_ff;
   assign rsp_chan.found_position = rsp_fpos_ff;
   assign rsp_chan.list_length    = rsp_len_ff;
   assign rsp_chan.is_empty       = rsp_empty_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_scan_launch: assert property (@(posedge clock) disable iff (reset)
      (accept && scan_op) |=> (launch_ff && (state_ff == ST_SCAN)))
      else $error("scan request did not launch a probe");

   a_probe_in_scan: assert property (@(posedge clock) disable iff (reset)
      probe_f[LIST_DEPTH].valid |-> (state_ff == ST_SCAN))
      else $error("probe left the chain outside the scan state");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_len_ff == '0)))
      else $error("is_empty disagrees with list_length");

   a_count_at_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> $past(fire))
      else $error("list length changed outside a commit");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside the commit state");

endmodule

`default_nettype wire

[tb/positional_array_list_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of positional_array_list: directed table, then random traffic.
// Depends on pal_pkg, pal_req_if, pal_rsp_if and the positional_array_list RTL.

module positional_array_list_tb;

   localparam int LIST_DEPTH   = 64;
   // Random items on top of the directed table; about 550 transfers in all.
   localparam int RANDOM_ITEMS = 520;
   // Slowest item: probe walk, then response stall, then a long sender gap.
   // The limit lies well above what about 600 items at that cost would take.
   localparam int CYCLE_LIMIT  = 500000;

   // Opcodes the block does not implement; they must be rejected.
   localparam logic [pal_pkg::OPCODE_WIDTH-1:0] OP_RSVD5 = 3'd5;
   localparam logic [pal_pkg::OPCODE_WIDTH-1:0] OP_RSVD6 = 3'd6;
   localparam logic [pal_pkg::OPCODE_WIDTH-1:0] OP_RSVD7 = 3'd7;

   // Values that recur on purpose, so finds meet duplicates and the all-0/all-1 words.
   localparam logic [pal_pkg::VALUE_WIDTH-1:0] VALUE_POOL [0:7] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0
   };

   typedef struct packed {
      logic                            ok;
      logic [pal_pkg::VALUE_WIDTH-1:0] read_value;
      logic [pal_pkg::POS_WIDTH-1:0]   found_position;
      logic [pal_pkg::POS_WIDTH-1:0]   list_length;
      logic                            is_empty;
   } list_result_type;

   typedef struct packed {
      logic [pal_pkg::OPCODE_WIDTH-1:0] opcode;
      logic [pal_pkg::POS_WIDTH-1:0]    position;
      logic [pal_pkg::VALUE_WIDTH-1:0]  value;
      logic                             typed;      // use the typed-in result below
      list_result_type                  want;
   } directed_row_type;

   typedef enum int {SC_FILL, SC_DRAIN, SC_NOISE, SC_MIXED} scenario_type;
   typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_PERIODIC, RX_LONG} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pal_req_if req_if ();
   pal_rsp_if rsp_if ();

   positional_array_list #(
      .LIST_DEPTH (LIST_DEPTH),
      .DATA_WIDTH (pal_pkg::VALUE_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #1 clock = ~clock;

   // Shadow copy of the list, advanced at each request transfer.
   logic [pal_pkg::VALUE_WIDTH-1:0] shadow_entries [0:LIST_DEPTH-1];
   int                              shadow_len = 0;

   list_result_type  expected_results [$];
   int               mismatch_count = 0;
   int unsigned      cycle_count = 0;
   int               random_sent = 0;
   int               burst_left = 0;
   logic             valid_dropped = 1'b1;   // a valid <= 0 is already scheduled / in effect
   rx_mode_type      rx_mode = RX_STEADY;
   directed_row_type directed_rows [0:24];

   // ------------------------------------------------------------------
   // Predictor: applies one request to the shadow list, returns the response.
   // ------------------------------------------------------------------
   function automatic list_result_type apply_list_op(logic [pal_pkg::OPCODE_WIDTH-1:0] op,
                                                     logic [pal_pkg::POS_WIDTH-1:0] pos,
                                                     logic [pal_pkg::VALUE_WIDTH-1:0] val);
      list_result_type r;
      int              p;
      r = '0;
      p = int'(pos);
      case (op)
         pal_pkg::OP_INSERT: begin
            // full list, position 0 or a position past the end: rejected, list untouched
            if (shadow_len < LIST_DEPTH && p >= 1 && p <= shadow_len + 1) begin
               for (int i = shadow_len; i >= p; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p-1] = val;
               shadow_len++;
               r.ok = 1'b1;
            end
         end
         pal_pkg::OP_DELETE: begin
            if (p >= 1 && p <= shadow_len) begin
               r.read_value = shadow_entries[p-1];
               for (int i = p; i < shadow_len; i++) shadow_entries[i-1] = shadow_entries[i];
               shadow_len--;
               r.ok = 1'b1;
            end
         end
         pal_pkg::OP_GET: begin
            if (p >= 1 && p <= shadow_len) begin
               r.read_value = shadow_entries[p-1];
               r.ok = 1'b1;
            end
         end
         pal_pkg::OP_FIND: begin
            // first match wins; position field is ignored
            for (int i = 0; i < shadow_len; i++) begin
               if (!r.ok && shadow_entries[i] == val) begin
                  r.found_position = pal_pkg::POS_WIDTH'(i + 1);
                  r.ok = 1'b1;
               end
            end
         end
         pal_pkg::OP_CLEAR: begin
            shadow_len = 0;
            r.ok = 1'b1;
         end
         default: ;   // unused opcodes: rejected, nothing changes
      endcase
      r.list_length = pal_pkg::POS_WIDTH'(shadow_len);
      r.is_empty    = (shadow_len == 0);
      return r;
   endfunction

   // Directed rows: typed_row carries a result readable at a glance (read_value 0,
   // found_position 0); free_row is left to the predictor.
   function automatic directed_row_type typed_row(logic [pal_pkg::OPCODE_WIDTH-1:0] op,
                                                  logic [pal_pkg::POS_WIDTH-1:0] pos,
                                                  logic [pal_pkg::VALUE_WIDTH-1:0] val,
                                                  logic ok,
                                                  logic [pal_pkg::POS_WIDTH-1:0] len);
      directed_row_type r;
      r = '0;
      r.opcode = op;
      r.position = pos;
      r.value = val;
      r.typed = 1'b1;
      r.want.ok = ok;
      r.want.list_length = len;
      r.want.is_empty = (len == 0);
      return r;
   endfunction

   function automatic directed_row_type free_row(logic [pal_pkg::OPCODE_WIDTH-1:0] op,
                                                 logic [pal_pkg::POS_WIDTH-1:0] pos,
                                                 logic [pal_pkg::VALUE_WIDTH-1:0] val);
      directed_row_type r;
      r = '0;
      r.opcode = op;
      r.position = pos;
      r.value = val;
      return r;
   endfunction

   // Mostly a legal position in 1..hi; wild_pct percent anywhere in the 7-bit field.
   function automatic logic [pal_pkg::POS_WIDTH-1:0] pick_position(int hi, int wild_pct);
      if (hi < 1 || $urandom_range(0, 99) < wild_pct)
         return pal_pkg::POS_WIDTH'($urandom_range(0, 127));
      return pal_pkg::POS_WIDTH'($urandom_range(1, hi));
   endfunction

   function automatic logic [pal_pkg::VALUE_WIDTH-1:0] pick_value();
      if ($urandom_range(0, 1) == 0) return VALUE_POOL[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Search keys hit an entry of the list most of the time.
   function automatic logic [pal_pkg::VALUE_WIDTH-1:0] pick_search_value();
      if (shadow_len > 0 && $urandom_range(0, 99) < 60)
         return shadow_entries[$urandom_range(0, shadow_len - 1)];
      return pick_value();
   endfunction

   task automatic report_mismatch(string what, logic [pal_pkg::VALUE_WIDTH-1:0] got,
                                  logic [pal_pkg::VALUE_WIDTH-1:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch: got %h expected %h", $time, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Sender: drive one request, hold until it transfers, then record the
   // expected response. Idles in bursts: a random gap after each burst.
   // ------------------------------------------------------------------
   task automatic send_request(logic [pal_pkg::OPCODE_WIDTH-1:0] op,
                               logic [pal_pkg::POS_WIDTH-1:0] pos,
                               logic [pal_pkg::VALUE_WIDTH-1:0] val, logic typed,
                               list_result_type want);
      list_result_type predicted;
      int              gap;
      req_if.valid    <= 1'b1;
      req_if.opcode   <= op;
      req_if.position <= pos;
      req_if.value    <= val;
      valid_dropped    = 1'b0;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // transfer at this edge
      predicted = apply_list_op(op, pos, val);
      expected_results.push_back(typed ? want : predicted);
      burst_left--;
      if (burst_left <= 0) begin
         case ($urandom_range(0, 19))
            0:       gap = $urandom_range(20, 80);
            1, 2, 3: gap = $urandom_range(5, 12);
            4, 5:    gap = 0;
            default: gap = $urandom_range(1, 4);
         endcase
         // some bursts are long stretches with no idling at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            valid_dropped = 1'b1;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Hold off the sender until every outstanding response has been seen.
   task automatic wait_for_drain();
      if (!valid_dropped) begin
         req_if.valid <= 1'b0;
         valid_dropped = 1'b1;
      end
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // One random sequence. Fill drives the list to full and then past it; drain
   // empties it and deletes once more; mixed is the bulk; noise is anything.
   task automatic run_scenario(scenario_type kind);
      int                               n;
      int                               r;
      logic [pal_pkg::OPCODE_WIDTH-1:0] op;
      logic [pal_pkg::POS_WIDTH-1:0]    pos;
      logic [pal_pkg::VALUE_WIDTH-1:0]  val;
      case (kind)
         SC_FILL:  n = LIST_DEPTH - shadow_len + 8;
         SC_DRAIN: n = shadow_len + 1;
         SC_NOISE: n = 8;
         default:  n = $urandom_range(10, 30);
      endcase
      for (int k = 0; k < n; k++) begin
         case (kind)
            SC_FILL: begin
               op  = pal_pkg::OP_INSERT;
               pos = pick_position(shadow_len + 1, 3);
               val = pick_value();
            end
            SC_DRAIN: begin
               op  = pal_pkg::OP_DELETE;
               pos = pick_position(shadow_len, 3);
               val = $urandom;
            end
            SC_NOISE: begin
               op  = pal_pkg::OPCODE_WIDTH'($urandom_range(0, 7));
               pos = pal_pkg::POS_WIDTH'($urandom_range(0, 127));
               val = $urandom;
            end
            default: begin
               r = $urandom_range(0, 99);
               val = $urandom;
               pos = pal_pkg::POS_WIDTH'($urandom_range(0, 127));
               if (r < 30) begin
                  op  = pal_pkg::OP_INSERT;
                  pos = pick_position(shadow_len + 1, 10);
                  val = pick_value();
               end else if (r < 50) begin
                  op  = pal_pkg::OP_DELETE;
                  pos = pick_position(shadow_len, 10);
               end else if (r < 65) begin
                  op  = pal_pkg::OP_GET;
                  pos = pick_position(shadow_len, 10);
               end else if (r < 85) begin
                  op  = pal_pkg::OP_FIND;
                  val = pick_search_value();
               end else if (r < 88) begin
                  op  = pal_pkg::OP_CLEAR;
               end else begin
                  op  = pal_pkg::OPCODE_WIDTH'($urandom_range(OP_RSVD5, OP_RSVD7));
               end
            end
         endcase
         send_request(op, pos, val, 1'b0, '0);
         random_sent++;
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: check each response transfer against the oldest expectation,
   // and drive ready from a stall pattern re-picked at random at regular points of cycle_count.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unrequested response, read_value", rsp_if.read_value, '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.ok !== want.ok)
               report_mismatch("ok", rsp_if.ok, want.ok);
            if (rsp_if.read_value !== want.read_value)
               report_mismatch("read_value", rsp_if.read_value, want.read_value);
            if (rsp_if.found_position !== want.found_position)
               report_mismatch("found_position", rsp_if.found_position, want.found_position);
            if (rsp_if.list_length !== want.list_length)
               report_mismatch("list_length", rsp_if.list_length, want.list_length);
            if (rsp_if.is_empty !== want.is_empty)
               report_mismatch("is_empty", rsp_if.is_empty, want.is_empty);
         end
      end
      if (cycle_count % 128 == 0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_STEADY:   rsp_if.ready <= 1'b1;
         RX_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
         RX_PERIODIC: rsp_if.ready <= (cycle_count % 8) >= 3;   // short periodic stalls
         default:     rsp_if.ready <= (cycle_count % 32) >= 12; // long periodic stalls
      endcase
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("positional_array_list_tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      int r;
      req_if.valid    = 1'b0;
      req_if.opcode   = pal_pkg::OP_INSERT;
      req_if.position = '0;
      req_if.value    = '0;
      rsp_if.ready    = 1'b0;

      // Directed part. List after the inserts: 5A5A5A5A, FFFFFFFF, 0, 12345678.
      directed_rows = '{
         typed_row(pal_pkg::OP_GET,    7'd0,   32'h0,         1'b0, 7'd0),  // get, empty
         typed_row(pal_pkg::OP_FIND,   7'd0,   32'h0,         1'b0, 7'd0),  // find, empty
         typed_row(pal_pkg::OP_DELETE, 7'd0,   32'h0,         1'b0, 7'd0),  // delete at 0
         typed_row(pal_pkg::OP_INSERT, 7'd0,   32'hA5A5_A5A5, 1'b0, 7'd0),  // insert at 0
         typed_row(pal_pkg::OP_INSERT, 7'd2,   32'hA5A5_A5A5, 1'b0, 7'd0),  // past length+1
         typed_row(pal_pkg::OP_INSERT, 7'd1,   32'hFFFF_FFFF, 1'b1, 7'd1),
         typed_row(pal_pkg::OP_INSERT, 7'd2,   32'h0,         1'b1, 7'd2),  // append
         free_row (pal_pkg::OP_INSERT, 7'd1,   32'h5A5A_5A5A),     // insert at head, shift
         free_row (pal_pkg::OP_INSERT, 7'd4,   32'h1234_5678),     // append at length+1
         free_row (pal_pkg::OP_INSERT, 7'd6,   32'h1),             // length+2, rejected
         free_row (pal_pkg::OP_INSERT, 7'd127, 32'h2),             // all position bits set
         free_row (pal_pkg::OP_GET,    7'd2,   32'h0),
         free_row (pal_pkg::OP_GET,    7'd5,   32'h0),             // one past the end
         free_row (pal_pkg::OP_FIND,   7'd0,   32'h0),
         free_row (pal_pkg::OP_FIND,   7'd0,   32'hDEAD_BEEF),     // no match
         free_row (pal_pkg::OP_INSERT, 7'd3,   32'hFFFF_FFFF),     // duplicate value
         free_row (pal_pkg::OP_FIND,   7'd127, 32'hFFFF_FFFF),     // first of two matches
         free_row (pal_pkg::OP_DELETE, 7'd1,   32'h0),             // head
         free_row (pal_pkg::OP_DELETE, 7'd4,   32'h0),             // tail
         free_row (pal_pkg::OP_DELETE, 7'd127, 32'hFFFF_FFFF),     // out of range
         free_row (OP_RSVD5,           7'd1,   32'h0),             // unused opcodes
         free_row (OP_RSVD6,           7'd64,  32'h0),
         free_row (OP_RSVD7,           7'd127, 32'hFFFF_FFFF),
         typed_row(pal_pkg::OP_CLEAR,  7'd0,   32'h0,         1'b1, 7'd0),
         typed_row(pal_pkg::OP_CLEAR,  7'd127, 32'hFFFF_FFFF, 1'b1, 7'd0)   // clear, empty
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_request(directed_rows[k].opcode, directed_rows[k].position,
                      directed_rows[k].value, directed_rows[k].typed, directed_rows[k].want);

      // Sender waits for every response before the random part.
      wait_for_drain();

      // Start random traffic by filling the list, so that full-list cases occur.
      run_scenario(SC_FILL);
      while (random_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 19);
         if (r == 0)       run_scenario(SC_FILL);
         else if (r <= 2)  run_scenario(SC_DRAIN);
         else if (r == 3)  run_scenario(SC_NOISE);
         else if (r == 4)  wait_for_drain();
         else              run_scenario(SC_MIXED);
      end

      // Let everything outstanding come back, then watch for stray responses.
      wait_for_drain();
      repeat (LIST_DEPTH + 8) @(posedge clock);

      if (mismatch_count == 0)
         $display("positional_array_list_tb: PASS");
      else
         $display("positional_array_list_tb: FAIL");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/pal_pkg.sv
hw/rtl/pal_req_if.sv
hw/rtl/pal_rsp_if.sv
hw/rtl/pal_cell.sv
hw/rtl/positional_array_list.sv
tb/positional_array_list_tb.sv
